// ----- hw/rtl/ghd_pkg.sv -----
// ghd_pkg: shared types, constants and the symbol lookup for the geohash decoder
// used by every module of the geohash_decoder block; no dependencies
package ghd_pkg;

    // geometry of the decode
    localparam int MAX_CHARS = 12;
    localparam int CNT_W     = 4;
    localparam int SYM_W     = 5;
    localparam int NSYM      = 1 << SYM_W;
    localparam int AXIS_W    = (MAX_CHARS * SYM_W + 1) / 2;
    localparam int AXN_W     = 5;
    localparam int COORD_W   = 32;

    // base32 alphabet, first symbol in the top byte
    localparam logic [8*NSYM-1:0] ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADCHAR = 2'd1,
        ST_TOOLONG = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } chr_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] latitude;
        logic signed [COORD_W-1:0] longitude;
        status_t                   status;
    } pos_t;

    // classified character as it travels through the queue
    typedef struct packed {
        logic             last;
        logic             bad;
        logic [SYM_W-1:0] value;
    } sym_t;

    // map an ascii code to its 5-bit symbol, flag codes outside the alphabet
    function automatic sym_t classify(logic [7:0] code, logic last);
        sym_t s;
        s.last  = last;
        s.bad   = 1'b1;
        s.value = '0;
        for (int k = 0; k < NSYM; k++) begin
            if (ALPHABET[8*(NSYM-1-k) +: 8] == code) begin
                s.bad   = 1'b0;
                s.value = SYM_W'(k);
            end
        end
        return s;
    endfunction

endpackage

// ----- hw/rtl/ghd_front.sv -----
// ghd_front: accepts characters and classifies them into alphabet symbols
// depends on ghd_pkg; feeds ghd_queue
module ghd_front (
    input  ghd_pkg::chr_t chr_data,
    input  logic          chr_valid,
    input  logic          q_full,
    output logic          chr_stall,
    output logic          push,
    output ghd_pkg::sym_t push_data
);
    import ghd_pkg::*;

    // accept whenever the queue has room
    assign chr_stall = q_full;
    assign push      = chr_valid & ~q_full;

    // symbol lookup
    assign push_data = classify(chr_data.char_code, chr_data.last_char);

endmodule

// ----- hw/rtl/ghd_queue.sv -----
// ghd_queue: two-entry queue of classified symbols between front and back
// depends on ghd_pkg
module ghd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ghd_pkg::sym_t push_data,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output ghd_pkg::sym_t head_data
);
    import ghd_pkg::*;

    sym_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/ghd_back.sv -----
// ghd_back: bisection state per axis, error tracking and the result register
// depends on ghd_pkg; pops symbols from ghd_queue
module ghd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  ghd_pkg::sym_t head_data,
    output logic          pop,
    input  logic          pos_stall,
    output logic          pos_valid,
    output ghd_pkg::pos_t pos_data
);
    import ghd_pkg::*;

    // each axis keeps the chosen-half bits as a prefix; the center follows from it
    logic [AXIS_W-1:0] lon_bits_reg, lon_bits_next;
    logic [AXIS_W-1:0] lat_bits_reg, lat_bits_next;
    logic [AXN_W-1:0]  lon_n_reg, lon_n_next;
    logic [AXN_W-1:0]  lat_n_reg, lat_n_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    status_t           err_reg, err_next;
    logic              out_valid_reg, out_valid_next;
    pos_t              out_data_reg, out_data_next;
    logic              out_free;
    logic [SYM_W-1:0]  v;

    // center of an interval given its prefix bits and prefix length
    function automatic logic signed [COORD_W-1:0] center(logic [AXIS_W-1:0] p,
                                                         logic [AXN_W-1:0] n);
        logic [COORD_W-1:0] u;
        u = COORD_W'({p, 1'b1}) << (AXN_W'(COORD_W - 1) - n);
        return {~u[COORD_W-1], u[COORD_W-2:0]};
    endfunction

    assign out_free  = ~out_valid_reg | ~pos_stall;
    assign pop       = head_valid & (~head_data.last | out_free);
    assign v         = head_data.value;
    assign pos_valid = out_valid_reg;
    assign pos_data  = out_data_reg;

    // per-character update and result formation
    always_comb
    begin
        lon_bits_next  = lon_bits_reg;
        lat_bits_next  = lat_bits_reg;
        lon_n_next     = lon_n_reg;
        lat_n_next     = lat_n_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg & pos_stall;

        if (pop)
        begin
            if (count_reg == CNT_W'(MAX_CHARS))
            begin
                if (err_reg == ST_OK)
                begin
                    err_next = ST_TOOLONG;
                end
            end
            else
            begin
                count_next = count_reg + 1'b1;
                if (head_data.bad)
                begin
                    if (err_reg == ST_OK)
                    begin
                        err_next = ST_BADCHAR;
                    end
                end
                else if (!count_reg[0])
                begin
                    // even character: longitude takes three bits
                    lon_bits_next = {lon_bits_reg[AXIS_W-4:0], v[4], v[2], v[0]};
                    lat_bits_next = {lat_bits_reg[AXIS_W-3:0], v[3], v[1]};
                    lon_n_next    = lon_n_reg + AXN_W'(3);
                    lat_n_next    = lat_n_reg + AXN_W'(2);
                end
                else
                begin
                    // odd character: latitude takes three bits
                    lat_bits_next = {lat_bits_reg[AXIS_W-4:0], v[4], v[2], v[0]};
                    lon_bits_next = {lon_bits_reg[AXIS_W-3:0], v[3], v[1]};
                    lat_n_next    = lat_n_reg + AXN_W'(3);
                    lon_n_next    = lon_n_reg + AXN_W'(2);
                end
            end

            if (head_data.last)
            begin
                out_valid_next       = 1'b1;
                out_data_next.status = err_next;
                if (err_next == ST_OK)
                begin
                    out_data_next.latitude  = center(lat_bits_next, lat_n_next);
                    out_data_next.longitude = center(lon_bits_next, lon_n_next);
                end
                else
                begin
                    out_data_next.latitude  = '0;
                    out_data_next.longitude = '0;
                end
                // back to the full intervals
                lon_bits_next = '0;
                lat_bits_next = '0;
                lon_n_next    = '0;
                lat_n_next    = '0;
                count_next    = '0;
                err_next      = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lon_bits_reg  <= '0;
            lat_bits_reg  <= '0;
            lon_n_reg     <= '0;
            lat_n_reg     <= '0;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lon_bits_reg  <= lon_bits_next;
            lat_bits_reg  <= lat_bits_next;
            lon_n_reg     <= lon_n_next;
            lat_n_reg     <= lat_n_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ----- hw/rtl/geohash_decoder.sv -----
// geohash_decoder: one character per transfer, one position per terminated string.
// Throughput: one character per cycle while the result output is not stalled.
// Path: the last character passes through a queue entry register and then the result
// register; each character still waiting ahead of it in the queue delays the position.
// Reset: asynchronous, active low; intervals, counters, queue and result valid clear.
// Depends on ghd_pkg, ghd_front, ghd_queue, ghd_back.
module geohash_decoder (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          chr_valid,
    output logic          chr_stall,
    input  ghd_pkg::chr_t chr_data,
    output logic          pos_valid,
    input  logic          pos_stall,
    output ghd_pkg::pos_t pos_data
);
    import ghd_pkg::*;

    logic q_full;
    logic push;
    sym_t push_data;
    logic pop;
    logic head_valid;
    sym_t head_data;

    // classify incoming characters
    ghd_front u_front (
        .chr_data  (chr_data),
        .chr_valid (chr_valid),
        .q_full    (q_full),
        .chr_stall (chr_stall),
        .push      (push),
        .push_data (push_data)
    );

    // decoupling queue
    ghd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // bisection and result
    ghd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .pos_stall  (pos_stall),
        .pos_valid  (pos_valid),
        .pos_data   (pos_data)
    );

`ifndef NO_ASSERTIONS
    // an error result carries no coordinates
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pos_valid && pos_data.status != ST_OK |->
            pos_data.latitude == '0 && pos_data.longitude == '0)
        else $error("error result with nonzero coordinates");

    // a center lies strictly inside the full range
    a_lat_inside: assert property (@(posedge clk) disable iff (!rst_n)
        pos_valid && pos_data.status == ST_OK |-> pos_data.latitude != 32'sh8000_0000)
        else $error("latitude center on range edge");

    a_lon_inside: assert property (@(posedge clk) disable iff (!rst_n)
        pos_valid && pos_data.status == ST_OK |-> pos_data.longitude != 32'sh8000_0000)
        else $error("longitude center on range edge");

    // the queue only refuses characters when the back end is blocked on a result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        chr_stall |-> pos_valid && $past(pos_stall))
        else $error("input stalled without a blocked result");
`endif

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for geohash_decoder, characters in, positions out
// keeps its own interval-bisection tracker and compares every position transfer
// depends on ghd_pkg and geohash_decoder
module tb;
    import ghd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_TAIL  = 150;
    localparam int STIM_ITEMS  = 1350;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic chr_valid = 1'b0;
    logic chr_stall;
    chr_t chr_data = '0;
    logic pos_valid;
    logic pos_stall = 1'b0;
    pos_t pos_data;

    geohash_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr_data  (chr_data),
        .pos_valid (pos_valid),
        .pos_stall (pos_stall),
        .pos_data  (pos_data)
    );

    // clock, period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    string gh_symbols = "0123456789bcdefghjkmnpqrstuvwxyz";

    chr_t pending_chars[$];
    pos_t expected_positions[$];
    int   mismatches = 0;
    int   cycle_count = 0;
    logic chr_taken = 1'b0;
    int   chr_gap = 0;
    int   pos_gap = 0;

    // running decode of the current string
    logic signed [32:0] lat_lo = -33'sd2147483648;
    logic signed [32:0] lat_hi = 33'sd2147483648;
    logic signed [32:0] lon_lo = -33'sd2147483648;
    logic signed [32:0] lon_hi = 33'sd2147483648;
    logic [3:0]         chars_seen = '0;
    status_t            string_err = ST_OK;

    // symbol index of an ascii code, -1 when outside the alphabet
    function automatic int symbol_index(logic [7:0] code);
        for (int k = 0; k < 32; k++)
        begin
            if (gh_symbols[k] == code)
                return k;
        end
        return -1;
    endfunction

    function automatic logic signed [32:0] midpoint(logic signed [32:0] lo,
                                                    logic signed [32:0] hi);
        logic signed [33:0] sum;
        sum = 34'(lo) + 34'(hi);
        return sum[33:1];
    endfunction

    // fold one accepted character into the intervals, queue a position on the last one
    task automatic track_char(chr_t c);
        int                 sym;
        logic               bit_val;
        logic [5:0]         bit_pos;
        logic signed [32:0] mid;
        pos_t               p;
        if (chars_seen >= 4'(MAX_CHARS))
        begin
            if (string_err == ST_OK)
                string_err = ST_TOOLONG;
        end
        else
        begin
            sym = symbol_index(c.char_code);
            if (sym < 0)
            begin
                if (string_err == ST_OK)
                    string_err = ST_BADCHAR;
            end
            else
            begin
                for (int k = 0; k < 5; k++)
                begin
                    bit_val = sym[4-k];
                    bit_pos = 6'(chars_seen) * 6'd5 + 6'(k);
                    if (!bit_pos[0])
                    begin
                        mid = midpoint(lon_lo, lon_hi);
                        if (bit_val) lon_lo = mid; else lon_hi = mid;
                    end
                    else
                    begin
                        mid = midpoint(lat_lo, lat_hi);
                        if (bit_val) lat_lo = mid; else lat_hi = mid;
                    end
                end
            end
            chars_seen = chars_seen + 4'd1;
        end
        if (c.last_char)
        begin
            p = '0;
            p.status = string_err;
            if (string_err == ST_OK)
            begin
                mid = midpoint(lat_lo, lat_hi);
                p.latitude = mid[31:0];
                mid = midpoint(lon_lo, lon_hi);
                p.longitude = mid[31:0];
            end
            expected_positions = {expected_positions, p};
            lat_lo = -33'sd2147483648;
            lat_hi = 33'sd2147483648;
            lon_lo = -33'sd2147483648;
            lon_hi = 33'sd2147483648;
            chars_seen = '0;
            string_err = ST_OK;
        end
    endtask

    task automatic push_char(logic [7:0] code, logic last);
        chr_t c;
        c.char_code = code;
        c.last_char = last;
        pending_chars = {pending_chars, c};
    endtask

    // character driver, changes at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!chr_valid || chr_taken))
        begin
            if (chr_gap > 0)
            begin
                chr_valid <= 1'b0;
                chr_gap = chr_gap - 1;
            end
            else if (pending_chars.size() > 0)
            begin
                if (pending_chars.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                begin
                    chr_valid <= 1'b0;
                    chr_gap = $urandom_range(0, 2);
                end
                else
                begin
                    chr_valid <= 1'b1;
                    chr_data  <= pending_chars.pop_front();
                end
            end
            else
                chr_valid <= 1'b0;
        end
    end

    // position stall, random bursts until the tail of the run
    always @(negedge clk)
    begin
        if (pos_gap > 0)
        begin
            pos_stall <= 1'b1;
            pos_gap = pos_gap - 1;
        end
        else if (rst_n && pending_chars.size() > QUIET_TAIL && $urandom_range(0, 4) == 0)
        begin
            pos_stall <= 1'b1;
            pos_gap = $urandom_range(0, 2);
        end
        else
            pos_stall <= 1'b0;
    end

    // monitor: check position transfers, then track character transfers
    always @(posedge clk)
    begin
        pos_t want;
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else if (!rst_n)
            chr_taken <= 1'b0;
        else
        begin
            chr_taken <= chr_valid && !chr_stall;
            if (pos_valid && !pos_stall)
            begin
                if (expected_positions.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected position: expected none actual %p",
                             $time, pos_data);
                end
                else
                begin
                    want = expected_positions.pop_front();
                    if (pos_data.latitude !== want.latitude)
                    begin
                        mismatches++;
                        $display("%0t latitude mismatch: expected %0d actual %0d",
                                 $time, want.latitude, pos_data.latitude);
                    end
                    if (pos_data.longitude !== want.longitude)
                    begin
                        mismatches++;
                        $display("%0t longitude mismatch: expected %0d actual %0d",
                                 $time, want.longitude, pos_data.longitude);
                    end
                    if (pos_data.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, pos_data.status);
                    end
                end
            end
            if (chr_valid && !chr_stall)
                track_char(chr_data);
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int kind;
        int len;
        logic [7:0] code;

        // directed: all-ones symbols at full length, lowest symbol, uppercase,
        // bad character after a good one, byte extremes
        for (int i = 0; i < MAX_CHARS; i++)
            push_char("z", i == MAX_CHARS - 1);
        push_char("0", 1'b1);
        push_char("E", 1'b1);
        push_char("b", 1'b0);
        push_char("a", 1'b1);
        push_char(8'hFF, 1'b1);
        push_char(8'h00, 1'b1);

        // random strings: mostly well formed, some too long, some noise
        while (pending_chars.size() < STIM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
                len = ($urandom_range(0, 3) == 0) ? MAX_CHARS : $urandom_range(1, MAX_CHARS);
            else if (kind < 82)
                len = $urandom_range(MAX_CHARS + 1, MAX_CHARS + 3);
            else
                len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                if (kind < 82 && $urandom_range(0, 39) != 0)
                    code = gh_symbols[$urandom_range(0, 31)];
                else
                    code = 8'($urandom_range(0, 255));
                push_char(code, i == len - 1);
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_chars.size() > 0 || chr_valid)
            @(posedge clk);
        while (expected_positions.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
